// File: rtl/multi_pipe_byte_fifo_top_defines.svh
// Assertion macros shared by the multi-pipe byte FIFO RTL.
`ifndef MULTI_PIPE_BYTE_FIFO_TOP_DEFINES_SVH
`define MULTI_PIPE_BYTE_FIFO_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MPBF_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MPBF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check that a condition implies another in the same cycle.
`define MPBF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/mpbf_pkg.sv
// Shared constants, types and helpers of the multi-pipe byte FIFO.
`default_nettype none
package mpbf_pkg;

   localparam int NUM_PIPES  = 16;
   localparam int FIFO_DEPTH = 4096;

   localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W = (NUM_PIPES * FIFO_DEPTH > 1) ? $clog2(NUM_PIPES * FIFO_DEPTH) : 1;
   localparam int STORE_DEPTH = NUM_PIPES * FIFO_DEPTH;

   // Fixed field widths of the item channels.
   localparam int KIND_W   = 3;
   localparam int PIDX_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int TCOUNT_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef logic [PIPE_W-1:0] pipe_sel_type;
   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC    = 3'd0,
      KIND_WRITE    = 3'd1,
      KIND_READ     = 3'd2,
      KIND_CLOSE_RD = 3'd3,
      KIND_CLOSE_WR = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_EOS       = 3'd3,
      ST_BROKEN    = 3'd4,
      ST_NONE_FREE = 3'd5,
      ST_UNUSED    = 3'd6
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic load_rdata;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic read_pending;
   } dp_status_type;

   function automatic addr_type slot_addr(pipe_sel_type pipe, ptr_type pos);
      slot_addr = addr_type'(addr_type'(pipe) * addr_type'(FIFO_DEPTH)) + addr_type'(pos);
   endfunction

endpackage
`default_nettype wire

// File: rtl/multi_pipe_byte_fifo_top.sv
// Top level of the multi-pipe byte FIFO: a pool of byte ring buffers, one per pipe.
//
//   Channel  Direction  Payload
//   req_*    in         tuser kind, tdata pipe_index/data_byte, tlast final_byte
//   rsp_*    out        tuser status, tdata granted_pipe/read_byte/transfer_count
//
// One item is in flight at a time: accept, execute, then present the result.
// The result is offered after the execute state, and for a read that returns a
// byte after a further wait state, since the byte store is a RAM with a
// registered read port. The next item can be accepted in the cycle after the
// result is taken. A stalled result holds in its output registers until
// rsp_tready rises. Synchronous reset frees all pipes and clears the counter;
// the byte store has no clearing pass, as every read reaches a written entry.
`default_nettype none
`include "multi_pipe_byte_fifo_top_defines.svh"
module multi_pipe_byte_fifo_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request items.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // pipe_index[3:0], data_byte[11:4], zero pad
   input  wire logic [mpbf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [mpbf_pkg::KIND_W-1:0]          req_tuser,  // kind[2:0]
   input  wire logic                                 req_tlast,  // final_byte
   // Result items.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // granted_pipe[3:0], read_byte[11:4], transfer_count[27:12], zero pad
   output logic      [mpbf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic      [mpbf_pkg::STATUS_W-1:0]        rsp_tuser   // status[2:0]
);

   mpbf_pkg::ctl_cmd_type   cmd;
   mpbf_pkg::dp_status_type stat;

   // Sequence each item: capture, execute, wait for store data, hold result.
   mpbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Pipe state, byte store and result registers.
   mpbf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Block stays busy after taking an item.
   `MPBF_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted while busy")
   // Never offer a result while open for a new item.
   `MPBF_ASSERT_NOW(a_ready_excl_valid, !(req_tready && rsp_tvalid), "ready and result together")
   // Return to idle once the result is taken.
   `MPBF_ASSERT_NEXT(a_idle_after_rsp, rsp_tvalid && rsp_tready, req_tready && !rsp_tvalid, "no return to idle")
   // Only a successful item carries a read byte.
   `MPBF_ASSERT_IMPL(a_byte_only_ok, rsp_tvalid && (rsp_tuser != mpbf_pkg::ST_OK), rsp_tdata[11:4] == 8'd0, "byte on failed item")

endmodule
`default_nettype wire

// File: rtl/mpbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/mpbf_ctrl.sv
// Sequencing state machine of the multi-pipe byte FIFO.
`default_nettype none
module mpbf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire mpbf_pkg::dp_status_type stat,
   output mpbf_pkg::ctl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;
   logic      exec_ff;
   logic      load_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
         exec_ff       <= 1'b0;
         load_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff      <= S_EXEC;
                  req_tready_ff <= 1'b0;
                  exec_ff       <= 1'b1;
               end
            end
            S_EXEC: begin
               exec_ff <= 1'b0;
               if (stat.read_pending) begin
                  state_ff <= S_WAIT;
                  load_ff  <= 1'b1;
               end else begin
                  state_ff      <= S_RESP;
                  rsp_tvalid_ff <= 1'b1;
               end
            end
            S_WAIT: begin
               load_ff       <= 1'b0;
               state_ff      <= S_RESP;
               rsp_tvalid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_tready) begin
                  state_ff      <= S_IDLE;
                  rsp_tvalid_ff <= 1'b0;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready     = req_tready_ff;
   assign rsp_tvalid     = rsp_tvalid_ff;
   assign cmd.capture    = req_tvalid & req_tready_ff;
   assign cmd.exec       = exec_ff;
   assign cmd.load_rdata = load_ff;

endmodule
`default_nettype wire

// File: rtl/mpbf_dp.sv
// Datapath: per-pipe state, byte store, transfer counter and result registers.
`default_nettype none
module mpbf_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mpbf_pkg::ctl_cmd_type                 cmd,
   output mpbf_pkg::dp_status_type                    stat,
   input  wire logic [mpbf_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic [mpbf_pkg::KIND_W-1:0]           req_tuser,
   input  wire logic                                  req_tlast,
   output logic      [mpbf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic      [mpbf_pkg::STATUS_W-1:0]         rsp_tuser
);

   localparam int WIDE_W = mpbf_pkg::PTR_W + 2;

   // Captured item.
   logic [mpbf_pkg::KIND_W-1:0] kind_ff;
   logic [mpbf_pkg::PIDX_W-1:0] pipe_ff;
   logic [mpbf_pkg::BYTE_W-1:0] byte_ff;
   logic                        final_ff;

   // Per-pipe state.
   mpbf_pkg::ptr_type           head_ff [mpbf_pkg::NUM_PIPES];
   mpbf_pkg::cnt_type           fill_ff [mpbf_pkg::NUM_PIPES];
   logic [mpbf_pkg::NUM_PIPES-1:0] reader_ff;
   logic [mpbf_pkg::NUM_PIPES-1:0] writer_ff;
   logic [mpbf_pkg::NUM_PIPES-1:0] in_use_ff;
   logic [mpbf_pkg::TCOUNT_W-1:0]  moved_ff;

   // Result registers.
   mpbf_pkg::status_type          status_ff;
   logic [mpbf_pkg::PIDX_W-1:0]   granted_ff;
   logic [mpbf_pkg::BYTE_W-1:0]   rbyte_ff;
   logic [mpbf_pkg::TCOUNT_W-1:0] tcount_ff;

   // Next values.
   logic                          upd_en;
   mpbf_pkg::pipe_sel_type        upd_idx;
   mpbf_pkg::ptr_type             head_in;
   mpbf_pkg::cnt_type             fill_in;
   logic                          reader_in;
   logic                          writer_in;
   logic                          in_use_in;
   logic [mpbf_pkg::TCOUNT_W-1:0] moved_in;
   mpbf_pkg::status_type          status_in;
   logic [mpbf_pkg::PIDX_W-1:0]   granted_in;
   logic [mpbf_pkg::TCOUNT_W-1:0] tcount_in;

   mpbf_pkg::pipe_sel_type        pipe_sel;
   logic                          pipe_ok;
   mpbf_pkg::ptr_type             cur_head;
   mpbf_pkg::cnt_type             cur_fill;
   logic                          free_found;
   mpbf_pkg::pipe_sel_type        free_idx;
   logic [mpbf_pkg::TCOUNT_W-1:0] moved_inc;
   logic [WIDE_W-1:0]             tail_wide;
   mpbf_pkg::ptr_type             tail_pos;
   mpbf_pkg::ptr_type             head_next;
   logic                          wr_go;
   logic                          rd_go;
   logic [mpbf_pkg::BYTE_W-1:0]   ram_rdata;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_tuser;
         pipe_ff  <= req_tdata[mpbf_pkg::PIDX_W-1:0];
         byte_ff  <= req_tdata[mpbf_pkg::PIDX_W +: mpbf_pkg::BYTE_W];
         final_ff <= req_tlast;
      end
   end

   assign pipe_sel = mpbf_pkg::pipe_sel_type'(pipe_ff);
   assign pipe_ok  = (32'(pipe_ff) < mpbf_pkg::NUM_PIPES) && in_use_ff[pipe_sel];
   assign cur_head = head_ff[pipe_sel];
   assign cur_fill = fill_ff[pipe_sel];

   // Lowest free pipe.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = mpbf_pkg::NUM_PIPES - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = mpbf_pkg::pipe_sel_type'(i);
         end
      end
   end

   assign moved_inc = (moved_ff == '1) ? moved_ff : moved_ff + 1'b1;
   assign head_next = (cur_head == mpbf_pkg::ptr_type'(mpbf_pkg::FIFO_DEPTH - 1)) ?
                      '0 : mpbf_pkg::ptr_type'(cur_head + 1'b1);
   assign tail_wide = WIDE_W'(cur_head) + WIDE_W'(mpbf_pkg::FIFO_DEPTH) - WIDE_W'(cur_fill);
   assign tail_pos  = (tail_wide >= WIDE_W'(mpbf_pkg::FIFO_DEPTH)) ?
                      mpbf_pkg::ptr_type'(tail_wide - WIDE_W'(mpbf_pkg::FIFO_DEPTH)) :
                      mpbf_pkg::ptr_type'(tail_wide);

   always_comb begin
      upd_en     = 1'b0;
      upd_idx    = pipe_sel;
      head_in    = cur_head;
      fill_in    = cur_fill;
      reader_in  = reader_ff[pipe_sel];
      writer_in  = writer_ff[pipe_sel];
      in_use_in  = in_use_ff[pipe_sel];
      moved_in   = moved_ff;
      status_in  = mpbf_pkg::ST_OK;
      granted_in = '0;
      tcount_in  = '0;
      wr_go      = 1'b0;
      rd_go      = 1'b0;
      unique case (kind_ff)
         mpbf_pkg::KIND_ALLOC: begin
            if (free_found) begin
               upd_en     = 1'b1;
               upd_idx    = free_idx;
               head_in    = '0;
               fill_in    = '0;
               reader_in  = 1'b1;
               writer_in  = 1'b1;
               in_use_in  = 1'b1;
               granted_in = mpbf_pkg::PIDX_W'(free_idx);
            end else begin
               status_in = mpbf_pkg::ST_NONE_FREE;
            end
         end
         mpbf_pkg::KIND_WRITE: begin
            if (!pipe_ok) begin
               status_in = mpbf_pkg::ST_UNUSED;
            end else begin
               if (!reader_ff[pipe_sel]) begin
                  status_in = mpbf_pkg::ST_BROKEN;
                  tcount_in = moved_ff;
               end else if (cur_fill >= mpbf_pkg::cnt_type'(mpbf_pkg::FIFO_DEPTH)) begin
                  status_in = mpbf_pkg::ST_FULL;
                  tcount_in = moved_ff;
               end else begin
                  wr_go     = 1'b1;
                  upd_en    = 1'b1;
                  head_in   = head_next;
                  fill_in   = mpbf_pkg::cnt_type'(cur_fill + 1'b1);
                  tcount_in = moved_inc;
               end
               moved_in = final_ff ? '0 : tcount_in;
            end
         end
         mpbf_pkg::KIND_READ: begin
            if (!pipe_ok) begin
               status_in = mpbf_pkg::ST_UNUSED;
            end else begin
               if (cur_fill == '0) begin
                  status_in = writer_ff[pipe_sel] ? mpbf_pkg::ST_EMPTY : mpbf_pkg::ST_EOS;
                  tcount_in = moved_ff;
               end else begin
                  rd_go     = 1'b1;
                  upd_en    = 1'b1;
                  fill_in   = mpbf_pkg::cnt_type'(cur_fill - 1'b1);
                  tcount_in = moved_inc;
               end
               moved_in = final_ff ? '0 : tcount_in;
            end
         end
         mpbf_pkg::KIND_CLOSE_RD, mpbf_pkg::KIND_CLOSE_WR: begin
            if (!pipe_ok) begin
               status_in = mpbf_pkg::ST_UNUSED;
            end else begin
               upd_en = 1'b1;
               if (kind_ff == mpbf_pkg::KIND_CLOSE_RD) begin
                  reader_in = 1'b0;
               end else begin
                  writer_in = 1'b0;
               end
               in_use_in = reader_in | writer_in;
            end
         end
         default: begin
            // Unknown kinds change nothing and answer ok.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpbf_pkg::NUM_PIPES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         reader_ff <= '0;
         writer_ff <= '0;
         in_use_ff <= '0;
         moved_ff  <= '0;
      end else if (cmd.exec) begin
         if (upd_en) begin
            head_ff[upd_idx]   <= head_in;
            fill_ff[upd_idx]   <= fill_in;
            reader_ff[upd_idx] <= reader_in;
            writer_ff[upd_idx] <= writer_in;
            in_use_ff[upd_idx] <= in_use_in;
         end
         moved_ff <= moved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         tcount_ff  <= tcount_in;
         rbyte_ff   <= '0;
      end else if (cmd.load_rdata) begin
         rbyte_ff <= ram_rdata;
      end
   end

   mpbf_ram #(
      .WIDTH (mpbf_pkg::BYTE_W),
      .DEPTH (mpbf_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec & wr_go),
      .wr_addr (mpbf_pkg::slot_addr(pipe_sel, cur_head)),
      .wr_data (byte_ff),
      .rd_en   (cmd.exec & rd_go),
      .rd_addr (mpbf_pkg::slot_addr(pipe_sel, tail_pos)),
      .rd_data (ram_rdata)
   );

   assign stat.read_pending = cmd.exec & rd_go;

   assign rsp_tdata = {{(mpbf_pkg::RSP_DATA_W - mpbf_pkg::TCOUNT_W - mpbf_pkg::BYTE_W
                         - mpbf_pkg::PIDX_W){1'b0}},
                       tcount_ff, rbyte_ff, granted_ff};
   assign rsp_tuser = status_ff;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the multi-pipe byte FIFO: directed, random and stream items.
`timescale 1ns / 100ps
module tb_top;
   import mpbf_pkg::*;

   // Cycles with no item moving on either side before the run is declared hung.
   localparam int WATCHDOG_LIMIT   = 4000;
   // Length of the deliberate receiver hold-off.
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int RANDOM_PER_PHASE = 240;
   // Bytes written and then read back in the closing stream.
   localparam int STREAM_BYTES     = 32;
   localparam int PAD_W            = REQ_DATA_W - PIDX_W - BYTE_W;

   // Kind codes the block has no operation for; it must ignore them.
   localparam logic [KIND_W-1:0]   KIND_UNDEF_LO = 3'd5;
   localparam logic [KIND_W-1:0]   KIND_UNDEF_HI = 3'd7;
   localparam logic [TCOUNT_W-1:0] COUNT_CEILING = '1;

   typedef struct {
      logic [KIND_W-1:0] kind;   // raw code, may lie outside kind_type
      logic [PIDX_W-1:0] pipe_index;
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
   } pipe_req_type;

   typedef struct {
      status_type          status;
      logic [PIDX_W-1:0]   granted_pipe;
      logic [BYTE_W-1:0]   read_byte;
      logic [TCOUNT_W-1:0] transfer_count;
   } pipe_rsp_type;

   // Pipe pool state as the block should hold it, plus the results still owed.
   // Each pipe's ring buffer is kept as a byte queue: only its order matters.
   class pipe_pool_scoreboard;
      logic [BYTE_W-1:0]   buffered[NUM_PIPES][$];
      bit                  reader_open[NUM_PIPES];
      bit                  writer_open[NUM_PIPES];
      bit                  taken[NUM_PIPES];
      logic [TCOUNT_W-1:0] moved_count;
      pipe_rsp_type        awaited[$];
      int                  mismatches;
      int                  results_checked;
      int                  status_tally[8];

      function new();
         moved_count     = '0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      function void count_move();
         if (moved_count != COUNT_CEILING) moved_count++;
      endfunction

      function void report(string what);
         mismatches++;
         $error("%s", what);
      endfunction

      function int free_count();
         int n;
         n = 0;
         for (int i = 0; i < NUM_PIPES; i++) if (!taken[i]) n++;
         return n;
      endfunction

      function int pick_taken();
         int live[$];
         for (int i = 0; i < NUM_PIPES; i++) if (taken[i]) live.push_back(i);
         if (live.size() == 0) return -1;
         return live[$urandom_range(live.size() - 1)];
      endfunction

      // Apply one accepted request to the pool and queue the result it owes.
      function void note_request(pipe_req_type rq);
         pipe_rsp_type r;
         int           p;
         bit           placed;
         r.status         = ST_OK;
         r.granted_pipe   = '0;
         r.read_byte      = '0;
         r.transfer_count = '0;
         p                = int'(rq.pipe_index);
         placed           = 1'b0;
         if (rq.kind == KIND_ALLOC) begin
            r.status = ST_NONE_FREE;
            for (int i = 0; i < NUM_PIPES; i++) begin
               if (!placed && !taken[i]) begin
                  placed         = 1'b1;
                  taken[i]       = 1'b1;
                  reader_open[i] = 1'b1;
                  writer_open[i] = 1'b1;
                  buffered[i].delete();
                  r.granted_pipe = PIDX_W'(i);
                  r.status       = ST_OK;
               end
            end
         end else if (rq.kind > KIND_CLOSE_WR) begin
            // undefined kind: nothing changes, all-zero result
         end else if (p >= NUM_PIPES || !taken[p]) begin
            r.status = ST_UNUSED;
         end else if (rq.kind == KIND_WRITE || rq.kind == KIND_READ) begin
            if (rq.kind == KIND_WRITE) begin
               // a missing reader wins over a full buffer
               if (!reader_open[p]) r.status = ST_BROKEN;
               else if (buffered[p].size() >= FIFO_DEPTH) r.status = ST_FULL;
               else begin
                  buffered[p].push_back(rq.data_byte);
                  count_move();
               end
            end else if (buffered[p].size() == 0) begin
               r.status = writer_open[p] ? ST_EMPTY : ST_EOS;
            end else begin
               r.read_byte = buffered[p].pop_front();
               count_move();
            end
            // the final mark reports the count even on failure, then clears it
            r.transfer_count = moved_count;
            if (rq.final_byte) moved_count = '0;
         end else begin
            if (rq.kind == KIND_CLOSE_RD) reader_open[p] = 1'b0;
            else writer_open[p] = 1'b0;
            if (!reader_open[p] && !writer_open[p]) taken[p] = 1'b0;
         end
         awaited.push_back(r);
      endfunction

      // Compare one accepted result with the oldest owed one, field by field.
      function void check_result(logic [STATUS_W-1:0] got_status,
                                 logic [RSP_DATA_W-1:0] payload);
         pipe_rsp_type        e;
         logic [PIDX_W-1:0]   got_pipe;
         logic [BYTE_W-1:0]   got_byte;
         logic [TCOUNT_W-1:0] got_count;
         got_pipe  = payload[PIDX_W-1:0];
         got_byte  = payload[PIDX_W +: BYTE_W];
         got_count = payload[PIDX_W + BYTE_W +: TCOUNT_W];
         results_checked++;
         if (!$isunknown(got_status)) status_tally[got_status]++;
         if (awaited.size() == 0) begin
            report($sformatf("result with status %0d arrived while none was owed",
                             got_status));
            return;
         end
         e = awaited.pop_front();
         if (got_status !== e.status)
            report($sformatf("status: expected %0d, actual %0d", e.status, got_status));
         if (got_pipe !== e.granted_pipe)
            report($sformatf("granted_pipe: expected %0d, actual %0d",
                             e.granted_pipe, got_pipe));
         if (got_byte !== e.read_byte)
            report($sformatf("read_byte: expected 0x%02h, actual 0x%02h",
                             e.read_byte, got_byte));
         if (got_count !== e.transfer_count)
            report($sformatf("transfer_count: expected %0d, actual %0d",
                             e.transfer_count, got_count));
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   // Idle odds in percent for each side; the stimulus changes them per phase.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_off_pending = 1'b0;
   // Items with a defined kind; ignored kinds do not count toward a phase.
   int useful_items   = 0;
   int items_sent     = 0;

   pipe_pool_scoreboard pool_sb = new();

   multi_pipe_byte_fifo_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: check each item taken, then pick the next ready level.
   // A requested hold-off is counted down here, one cycle per edge.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) pool_sb.check_result(rsp_tuser, rsp_tdata);
         if (hold_off_pending) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no item moved for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, pool_sb.awaited.size());
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(1));
   endfunction

   // Offer one request item and hold it until accepted. Valid stays high into
   // the next item unless an idle cycle drops it, so it is never lowered and
   // raised in the same step.
   task automatic send_op(input logic [KIND_W-1:0] kind, input int pipe,
                          input logic [BYTE_W-1:0] data_byte, input bit final_byte);
      pipe_req_type rq;
      rq.kind       = kind;
      rq.pipe_index = PIDX_W'(pipe);
      rq.data_byte  = data_byte;
      rq.final_byte = final_byte;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {{PAD_W{1'b0}}, rq.data_byte, rq.pipe_index};
      req_tlast  <= rq.final_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pool_sb.note_request(rq);
      items_sent++;
      if (kind <= KIND_CLOSE_WR) useful_items++;
   endtask

   // Drop valid and hold off until every owed result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pool_sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Close both ends of every live pipe, in random order, sometimes twice.
   task automatic run_teardown();
      kind_type first_end;
      kind_type second_end;
      for (int p = 0; p < NUM_PIPES; p++) begin
         if (pool_sb.taken[p]) begin
            first_end  = $urandom_range(1) ? KIND_CLOSE_RD : KIND_CLOSE_WR;
            second_end = (first_end == KIND_CLOSE_RD) ? KIND_CLOSE_WR : KIND_CLOSE_RD;
            send_op(first_end, p, rand_byte(), rand_bit());
            if ($urandom_range(3) == 0)
               send_op(first_end, p, rand_byte(), rand_bit());
            send_op(second_end, p, rand_byte(), rand_bit());
         end
      end
   endtask

   // Random traffic, mostly well-formed transfers on live pipes, plus pool
   // floods, teardowns and fully random noise items.
   task automatic run_random(input int goal);
      int start_count;
      int pick;
      int p;
      int n;
      int m;
      start_count = useful_items;
      while (useful_items - start_count < goal) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // claim every free pipe, then one more allocate that finds none
            while (pool_sb.free_count() > 0)
               send_op(KIND_ALLOC, $urandom_range(15), rand_byte(), rand_bit());
            send_op(KIND_ALLOC, $urandom_range(15), rand_byte(), rand_bit());
         end else if (pick < 18) begin
            run_teardown();
         end else if (pick < 80) begin
            p = pool_sb.pick_taken();
            if (p < 0) begin
               send_op(KIND_ALLOC, $urandom_range(15), rand_byte(), rand_bit());
               p = pool_sb.pick_taken();
            end
            n = $urandom_range(1, 12);
            m = n + $urandom_range(0, 2);
            // now and then drop the reader first so the writes come back broken
            if ($urandom_range(7) == 0) send_op(KIND_CLOSE_RD, p, rand_byte(), 1'b0);
            for (int i = 0; i < n; i++)
               send_op(KIND_WRITE, p, rand_byte(), i == n - 1);
            // closing the writer turns the over-reads into end of stream
            if ($urandom_range(3) == 0)
               send_op(KIND_CLOSE_WR, p, rand_byte(), rand_bit());
            for (int i = 0; i < m; i++)
               send_op(KIND_READ, p, rand_byte(), i == m - 1);
         end else begin
            send_op(KIND_W'($urandom_range(7)), $urandom_range(15), rand_byte(),
                    rand_bit());
         end
      end
   endtask

   initial begin : stimulus
      int idle_pct[4];
      int stall_pct[4];
      idle_pct  = '{0, 75, 0, 37};
      stall_pct = '{0, 0, 75, 37};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every kind on a free pipe, ignored kinds, then one pipe
      // walked through empty, end of stream, writes after the writer closed,
      // a repeated close, a broken write, and reuse of a freed pipe.
      send_op(KIND_READ,     0,  8'h00, 1'b0);
      send_op(KIND_WRITE,    15, 8'hFF, 1'b1);
      send_op(KIND_CLOSE_RD, 5,  8'h00, 1'b0);
      send_op(KIND_CLOSE_WR, 10, 8'h00, 1'b0);
      send_op(KIND_UNDEF_HI, 15, 8'hFF, 1'b1);
      send_op(KIND_UNDEF_LO, 0,  8'h00, 1'b0);
      send_op(KIND_ALLOC,    15, 8'hFF, 1'b1);
      send_op(KIND_READ,     0,  8'h00, 1'b1);
      send_op(KIND_WRITE,    0,  8'h00, 1'b0);
      send_op(KIND_WRITE,    0,  8'hFF, 1'b1);
      send_op(KIND_CLOSE_WR, 0,  8'h00, 1'b0);
      send_op(KIND_READ,     0,  8'h00, 1'b0);
      send_op(KIND_READ,     0,  8'h00, 1'b1);
      send_op(KIND_READ,     0,  8'h00, 1'b0);
      send_op(KIND_CLOSE_WR, 0,  8'h00, 1'b0);
      send_op(KIND_WRITE,    0,  8'h5A, 1'b1);
      send_op(KIND_CLOSE_RD, 0,  8'h00, 1'b0);
      send_op(KIND_WRITE,    0,  8'h11, 1'b0);
      send_op(KIND_ALLOC,    0,  8'h00, 1'b0);
      send_op(KIND_ALLOC,    0,  8'h00, 1'b0);
      send_op(KIND_CLOSE_RD, 0,  8'h00, 1'b0);
      send_op(KIND_WRITE,    0,  8'hA5, 1'b1);
      send_op(KIND_CLOSE_WR, 0,  8'h00, 1'b0);
      send_op(KIND_ALLOC,    0,  8'h00, 1'b0);
      wait_for_results();

      // Random phases: no idling, sender idle, receiver stalling, both.
      // Partway through the first one the receiver holds off for a long
      // stretch while the sender keeps offering, so the block backs up.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         if (ph == 0) begin
            run_random(RANDOM_PER_PHASE / 2);
            hold_off_pending = 1'b1;
            run_random(RANDOM_PER_PHASE / 2);
         end else begin
            run_random(RANDOM_PER_PHASE);
         end
         wait_for_results();
      end

      // Stream on one pipe at full speed: write a burst with a final mark on
      // the last byte, then read it all back as one transfer.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_teardown();
      // every pipe is free now, so the allocate lands on pipe 0
      send_op(KIND_ALLOC, 0, 8'h00, 1'b0);
      for (int i = 0; i < STREAM_BYTES; i++)
         send_op(KIND_WRITE, 0, rand_byte(), i == STREAM_BYTES - 1);
      for (int i = 0; i < STREAM_BYTES; i++)
         send_op(KIND_READ, 0, rand_byte(), i == STREAM_BYTES - 1);
      run_teardown();

      // Drain, then let the clock run on so that any stray result still shows.
      wait_for_results();
      repeat (8) @(posedge clock);

      $display("Run summary: %0d items sent, %0d results checked, %0d mismatches",
               items_sent, pool_sb.results_checked, pool_sb.mismatches);
      $display("Statuses: ok %0d, full %0d, empty %0d, end of stream %0d,",
               pool_sb.status_tally[ST_OK], pool_sb.status_tally[ST_FULL],
               pool_sb.status_tally[ST_EMPTY], pool_sb.status_tally[ST_EOS],
               " broken %0d, none free %0d, unused %0d",
               pool_sb.status_tally[ST_BROKEN], pool_sb.status_tally[ST_NONE_FREE],
               pool_sb.status_tally[ST_UNUSED]);
      if (pool_sb.mismatches == 0 && pool_sb.awaited.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
